>>> src/bdc_pkg.sv
// Shared types, codes and glyph constants for the braille dot canvas.
`timescale 1ns / 1ps

package bdc_pkg;

   // Operation codes carried in the op field of an input item
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_PLOT  = 2'd1;
   localparam logic [1:0] OP_BRAILLE = 2'd2;
   localparam logic [1:0] OP_ASCII = 2'd3;

   // Configuration register indexes
   localparam logic [7:0] CSR_COLS_IN_USE = 8'd0;
   localparam logic [7:0] CSR_ROWS_IN_USE = 8'd1;

   // Register reset values
   localparam logic [8:0] COLS_RESET = 9'd80;
   localparam logic [6:0] ROWS_RESET = 7'd24;

   // UTF-8 pieces of the braille block starting at U+2800
   localparam logic [7:0] UTF8_LEAD      = 8'hE2;
   localparam logic [7:0] UTF8_MID_BASE  = 8'hA0;
   localparam logic [7:0] UTF8_CONT_BASE = 8'h80;

   // Ascii glyphs
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [15:0] dot_row;
      logic signed [15:0] dot_col;
      logic [5:0]         cell_row;
      logic [7:0]         cell_col;
   } bdc_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } bdc_rsp_type;

   // Request from the control logic to format one glyph
   typedef struct packed {
      logic       load;
      logic       ascii;
      logic [7:0] mask;
   } bdc_load_type;

   // Map a dot position inside a cell to its bit in the braille mask
   function automatic logic [2:0] dot_bit(input logic [1:0] row, input logic col);
      logic [2:0] b;
      case ({row, col})
         3'b000:  b = 3'd0;
         3'b001:  b = 3'd3;
         3'b010:  b = 3'd1;
         3'b011:  b = 3'd4;
         3'b100:  b = 3'd2;
         3'b101:  b = 3'd5;
         3'b110:  b = 3'd6;
         3'b111:  b = 3'd7;
         default: b = 3'd0;
      endcase
      return b;
   endfunction

endpackage

>>> src/braille_dot_canvas.sv
// Top level of the braille dot canvas: control, cell store and result queue.
`timescale 1ns / 1ps

// Dot canvas of MAX_CELL_ROWS x MAX_CELL_COLS text cells, each an 8-bit braille
// mask in one RAM with a registered read. A plot reads the cell, then writes back
// the mask with the dot set; a plot outside the dot area is dropped in its accept
// cycle. A read reads the cell, then formats its mask once the queue has room, and
// then streams three bytes (braille) or one byte (ascii) from the output queue,
// which drains while the next item is taken. A clear sweeps the store one cell a
// cycle and holds req_ready low until the last cell is written; the same
// clearing pass runs right after reset. Size registers are taken on csr_valid at
// any time and do not touch the store.
module braille_dot_canvas #(
   parameter int MAX_CELL_ROWS = 64,
   parameter int MAX_CELL_COLS = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bdc_pkg::bdc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bdc_pkg::bdc_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [7:0]           csr_index,
   input  logic [15:0]          csr_data
);

   import bdc_pkg::*;

   localparam int DEPTH = MAX_CELL_ROWS * MAX_CELL_COLS;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_MODIFY = 4'b0100,
      ST_LOOKUP = 4'b1000
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] clr_ptr_ff, clr_ptr_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [2:0]    bit_ff, bit_in;
   logic          inside_ff, inside_in;
   logic          ascii_ff, ascii_in;
   logic [8:0]    cols_in_use_ff;
   logic [6:0]    rows_in_use_ff;

   logic [6:0]    eff_rows;
   logic [8:0]    eff_cols;
   logic          plot_ok;
   logic          read_inside;
   logic [AW-1:0] plot_addr;
   logic [AW-1:0] read_addr;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   bdc_load_type  load_req;
   logic          can_load;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_in_use_ff <= COLS_RESET;
         rows_in_use_ff <= ROWS_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_COLS_IN_USE) begin
            cols_in_use_ff <= csr_data[8:0];
         end else if (csr_index == CSR_ROWS_IN_USE) begin
            rows_in_use_ff <= csr_data[6:0];
         end
      end
   end

   // Clamp the configured size to the store
   assign eff_rows = (32'(rows_in_use_ff) < 32'(MAX_CELL_ROWS)) ?
                     rows_in_use_ff : 7'(MAX_CELL_ROWS);
   assign eff_cols = (32'(cols_in_use_ff) < 32'(MAX_CELL_COLS)) ?
                     cols_in_use_ff : 9'(MAX_CELL_COLS);

   // Decode the plot target and the read target
   assign plot_ok = !req_data.dot_row[15] && !req_data.dot_col[15] &&
                    ({1'b0, req_data.dot_row[14:0]} < {7'd0, eff_rows, 2'b00}) &&
                    ({1'b0, req_data.dot_col[14:0]} < {6'd0, eff_cols, 1'b0});
   assign plot_addr = AW'(32'(req_data.dot_row[14:2]) * 32'(MAX_CELL_COLS) +
                          32'(req_data.dot_col[14:1]));

   assign read_inside = ({1'b0, req_data.cell_row} < eff_rows) &&
                        ({1'b0, req_data.cell_col} < eff_cols);
   assign read_addr = AW'(32'(req_data.cell_row) * 32'(MAX_CELL_COLS) +
                          32'(req_data.cell_col));

   assign req_ready = (state_ff == ST_IDLE);

   // Sequence clear sweeps, read-modify-write and lookups
   always_comb begin
      state_in   = state_ff;
      clr_ptr_in = clr_ptr_ff;
      addr_in    = addr_ff;
      bit_in     = bit_ff;
      inside_in  = inside_ff;
      ascii_in   = ascii_ff;
      wr_en      = 1'b0;
      wr_addr    = addr_ff;
      wr_data    = 8'd0;
      rd_en      = 1'b0;
      rd_addr    = read_addr;
      load_req   = '{load: 1'b0, ascii: ascii_ff, mask: 8'd0};
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ptr_ff;
            if (clr_ptr_ff == LAST_ADDR) begin
               clr_ptr_in = '0;
               state_in   = ST_IDLE;
            end else begin
               clr_ptr_in = clr_ptr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.op)
                  OP_CLEAR: begin
                     state_in = ST_CLEAR;
                  end
                  OP_PLOT: begin
                     if (plot_ok) begin
                        rd_en    = 1'b1;
                        rd_addr  = plot_addr;
                        addr_in  = plot_addr;
                        bit_in   = dot_bit(req_data.dot_row[1:0], req_data.dot_col[0]);
                        state_in = ST_MODIFY;
                     end
                  end
                  default: begin
                     rd_en     = read_inside;
                     rd_addr   = read_addr;
                     inside_in = read_inside;
                     ascii_in  = (req_data.op == OP_ASCII);
                     state_in  = ST_LOOKUP;
                  end
               endcase
            end
         end
         ST_MODIFY: begin
            wr_en    = 1'b1;
            wr_addr  = addr_ff;
            wr_data  = rd_data | (8'd1 << bit_ff);
            state_in = ST_IDLE;
         end
         ST_LOOKUP: begin
            if (can_load) begin
               load_req.load = 1'b1;
               load_req.mask = inside_ff ? rd_data : 8'd0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in   = ST_CLEAR;
            clr_ptr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ptr_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_ptr_ff <= clr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      bit_ff    <= bit_in;
      inside_ff <= inside_in;
      ascii_ff  <= ascii_in;
   end

   bdc_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_cells (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   bdc_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .load_req (load_req),
      .can_load (can_load),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // A write-back always follows the read issued in the idle state
   a_modify_after_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MODIFY) |-> ($past(state_ff) == ST_IDLE))
      else $error("write-back without a preceding read");

   // No item is taken during a clearing pass
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("item accepted during clear");

   // The sweep pointer rests at zero outside a clearing pass
   a_clr_ptr_rest: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CLEAR) |-> (clr_ptr_ff == '0))
      else $error("clear pointer moved outside clear");

   // A glyph is handed to the queue only when it has room
   a_load_has_room: assert property (@(posedge clock) disable iff (reset)
      load_req.load |-> can_load)
      else $error("glyph loaded into a busy queue");

endmodule

>>> src/bdc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module bdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/bdc_out_stage.sv
// Glyph formatter and result byte queue for the braille dot canvas.
`timescale 1ns / 1ps

module bdc_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  bdc_pkg::bdc_load_type load_req,
   output logic                 can_load,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bdc_pkg::bdc_rsp_type rsp_data
);

   import bdc_pkg::*;

   logic [7:0] bytes_ff [3];
   logic [7:0] bytes_in [3];
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       take;

   assign take      = rsp_valid && rsp_ready;
   assign can_load  = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data.out_byte = bytes_ff[0];
   assign rsp_data.last     = (cnt_ff == 2'd1);

   // Load a new glyph or shift out the byte just taken
   always_comb begin
      bytes_in = bytes_ff;
      cnt_in   = cnt_ff;
      if (load_req.load) begin
         if (load_req.ascii) begin
            bytes_in[0] = (load_req.mask != 8'd0) ? CHAR_STAR : CHAR_SPACE;
            cnt_in      = 2'd1;
         end else begin
            bytes_in[0] = UTF8_LEAD;
            bytes_in[1] = UTF8_MID_BASE | {6'd0, load_req.mask[7:6]};
            bytes_in[2] = UTF8_CONT_BASE | {2'd0, load_req.mask[5:0]};
            cnt_in      = 2'd3;
         end
      end else if (take) begin
         bytes_in[0] = bytes_ff[1];
         bytes_in[1] = bytes_ff[2];
         cnt_in      = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule
